[rtl/plid_pkg.sv]
package plid_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CMP_W    = 9;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
        logic [7:0]         position;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] entry_value;
        logic [4:0]         entry_count;
        logic               last_result;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_LIST
    } state_t;

    typedef struct packed {
        logic load_op;
        logic load_next;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
    } dp_sts_t;

endpackage

[rtl/positional_list_insert_delete.sv]
// Ordered list of up to 16 signed 32-bit entries held in a row of shift cells.
// Insert and delete shift cells in parallel in the accept cycle and give one
// result transaction in the next cycle; a new command is taken in the same cycle
// that result is taken, so these run at one command every cycle when the output
// side does not stall. List out gives one result per held entry, one per cycle
// unless stalled, the last marked by last_result; no command is taken until the
// final entry has gone. Command code three is taken and causes no result.
module positional_list_insert_delete (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  plid_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output plid_pkg::rsp_t rsp
);
    import plid_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    plid_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_command (req.command),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    plid_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

[rtl/plid_ctrl.sv]
module plid_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [1:0]        req_command,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  plid_pkg::dp_sts_t sts,
    output plid_pkg::dp_cmd_t cmd
);
    import plid_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   take;
    logic   accept;

    assign take   = (state_reg == ST_IDLE) || (state_reg == ST_SINGLE && !rsp_stall);
    assign accept = req_valid && take;

    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            case (req_command)
                CMD_INSERT, CMD_DELETE: state_next = ST_SINGLE;
                CMD_LIST:               state_next = sts.empty ? ST_SINGLE : ST_LIST;
                default:                state_next = ST_IDLE;
            endcase
        end
        else
        begin
            case (state_reg)
                ST_SINGLE:
                begin
                    if (!rsp_stall)
                        state_next = ST_IDLE;
                end
                ST_LIST:
                begin
                    if (!rsp_stall && sts.last)
                        state_next = ST_IDLE;
                end
                default: state_next = state_reg;
            endcase
        end
    end

    always_comb
    begin
        req_stall     = !take;
        rsp_valid     = (state_reg != ST_IDLE);
        cmd.load_op   = accept;
        cmd.load_next = (state_reg == ST_LIST) && !rsp_stall && !sts.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef ASSERT_OFF
    a_no_dual_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_op && cmd.load_next))
        else $error("new transaction loaded during list stream");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |-> !sts.empty)
        else $error("list stream with empty list");

    a_list_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_command == CMD_LIST && !sts.empty) |=> (state_reg == ST_LIST))
        else $error("list command did not start stream");
`endif

endmodule

[rtl/plid_dp.sv]
module plid_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  plid_pkg::req_t    req,
    input  plid_pkg::dp_cmd_t cmd,
    output plid_pkg::dp_sts_t sts,
    output plid_pkg::rsp_t    rsp
);
    import plid_pkg::*;

    logic signed [31:0] cells_reg [CAPACITY];
    logic signed [31:0] cells_next [CAPACITY];
    logic signed [31:0] up [CAPACITY];
    logic signed [31:0] down [CAPACITY];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic [CMP_W-1:0]   pos_w;
    logic [CMP_W-1:0]   cnt_w;
    logic [CMP_W-1:0]   ins_slot;
    logic [CMP_W-1:0]   del_slot;
    logic               empty;
    logic               full;
    logic               del_ok;

    assign pos_w    = {1'b0, req.position};
    assign cnt_w    = CMP_W'(count_reg);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign del_ok   = !empty && (req.position != '0) && (pos_w <= cnt_w);
    assign del_slot = pos_w - CMP_W'(1);

    always_comb
    begin
        if (pos_w <= CMP_W'(1))
            ins_slot = '0;
        else if (pos_w - CMP_W'(1) >= cnt_w)
            ins_slot = cnt_w;
        else
            ins_slot = pos_w - CMP_W'(1);
    end

    // neighbour taps for the parallel shift
    always_comb
    begin
        up[0]            = cells_reg[0];
        down[CAPACITY-1] = cells_reg[CAPACITY-1];
        for (int i = 1; i < CAPACITY; i++)
            up[i] = cells_reg[i-1];
        for (int i = 0; i < CAPACITY - 1; i++)
            down[i] = cells_reg[i+1];
    end

    always_comb
    begin
        cells_next = cells_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        rsp_next   = rsp_reg;

        if (cmd.load_op)
        begin
            rsp_next.status      = STS_OK;
            rsp_next.entry_value = '0;
            rsp_next.last_result = 1'b1;
            case (req.command)
                CMD_INSERT:
                begin
                    if (full)
                        rsp_next.status = STS_FULL;
                    else
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (CMP_W'(i) == ins_slot)
                                cells_next[i] = req.value;
                            else if (CMP_W'(i) > ins_slot)
                                cells_next[i] = up[i];
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_DELETE:
                begin
                    if (empty)
                        rsp_next.status = STS_EMPTY;
                    else if (!del_ok)
                        rsp_next.status = STS_NOT_FOUND;
                    else
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (CMP_W'(i) >= del_slot)
                                cells_next[i] = down[i];
                        end
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_LIST:
                begin
                    if (empty)
                        rsp_next.status = STS_EMPTY;
                    else
                    begin
                        rsp_next.entry_value = cells_reg[0];
                        rsp_next.last_result = (count_reg == CNT_W'(1));
                        idx_next             = IDX_W'(1);
                    end
                end
                default:
                begin
                    rsp_next = rsp_reg;
                end
            endcase
            rsp_next.entry_count = 5'(count_next);
        end
        else if (cmd.load_next)
        begin
            rsp_next.entry_value = cells_reg[idx_reg];
            rsp_next.last_result = (CMP_W'(idx_reg) + CMP_W'(1) == cnt_w);
            idx_next             = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cells_reg <= cells_next;
        rsp_reg   <= rsp_next;
    end

    assign sts.empty = empty;
    assign sts.last  = rsp_reg.last_result;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_stream_idx: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_next |-> (CMP_W'(idx_reg) < cnt_w))
        else $error("list stream index past end of list");
`endif

endmodule

[tb/sv/list_result_checker.sv]
module list_result_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_stall,
    input  plid_pkg::req_t  req,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  plid_pkg::rsp_t  rsp,
    output int              mismatches,
    output int              results_outstanding
);
    import plid_pkg::*;

    logic signed [31:0] cells [CAPACITY];
    int                 held_n;
    int                 errors = 0;
    rsp_t               list_results_due [$];

    function automatic rsp_t result_of(logic [1:0] status, logic signed [31:0] val, logic last);
        rsp_t r;
        r.status      = status;
        r.entry_value = val;
        r.entry_count = 5'(held_n);
        r.last_result = last;
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic apply_command(req_t r);
        int slot;
        int p;
        p = int'(r.position);
        case (r.command)
            CMD_INSERT:
                if (held_n >= CAPACITY)
                    list_results_due.push_back(result_of(STS_FULL, 32'sd0, 1'b1));
                else
                begin
                    if (p <= 1)
                        slot = 0;
                    else if (p - 1 >= held_n)
                        slot = held_n;
                    else
                        slot = p - 1;
                    for (int i = held_n; i > slot; i--)
                        cells[i] = cells[i - 1];
                    cells[slot] = r.value;
                    held_n++;
                    list_results_due.push_back(result_of(STS_OK, 32'sd0, 1'b1));
                end
            CMD_DELETE:
                if (held_n == 0)
                    list_results_due.push_back(result_of(STS_EMPTY, 32'sd0, 1'b1));
                else if (p == 0 || p > held_n)
                    list_results_due.push_back(result_of(STS_NOT_FOUND, 32'sd0, 1'b1));
                else
                begin
                    for (int i = p - 1; i + 1 < held_n; i++)
                        cells[i] = cells[i + 1];
                    held_n--;
                    list_results_due.push_back(result_of(STS_OK, 32'sd0, 1'b1));
                end
            CMD_LIST:
                if (held_n == 0)
                    list_results_due.push_back(result_of(STS_EMPTY, 32'sd0, 1'b1));
                else
                    for (int i = 0; i < held_n; i++)
                        list_results_due.push_back(result_of(STS_OK, cells[i], i == held_n - 1));
            default:
                ;
        endcase
    endtask

    task automatic check_result(rsp_t got);
        rsp_t want;
        if (list_results_due.size() == 0)
        begin
            report("unexpected transaction, entry_value", got.entry_value, 0);
            return;
        end
        want = list_results_due.pop_front();
        if (got.status !== want.status)
            report("status", got.status, want.status);
        if (got.entry_value !== want.entry_value)
            report("entry_value", got.entry_value, want.entry_value);
        if (got.entry_count !== want.entry_count)
            report("entry_count", got.entry_count, want.entry_count);
        if (got.last_result !== want.last_result)
            report("last_result", got.last_result, want.last_result);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_results_due.delete();
            held_n = 0;
            mismatches <= 0;
            results_outstanding <= 0;
        end
        else
        begin
            // result side first: a transaction accepted now cannot answer this edge's command
            if (rsp_valid && !rsp_stall)
                check_result(rsp);
            if (req_valid && !req_stall)
                apply_command(req);
            mismatches <= errors;
            results_outstanding <= list_results_due.size();
        end
    end

endmodule

[tb/sv/positional_list_insert_delete_tb.sv]
module positional_list_insert_delete_tb;

    import plid_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         SQUEEZE_CYCLES = 120;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    logic squeeze_req = 1'b0;
    int   mismatches;
    int   results_outstanding;
    int   items_sent = 0;

    positional_list_insert_delete dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    list_result_checker chk (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req_valid           (req_valid),
        .req_stall           (req_stall),
        .req                 (req),
        .rsp_valid           (rsp_valid),
        .rsp_stall           (rsp_stall),
        .rsp                 (rsp),
        .mismatches          (mismatches),
        .results_outstanding (results_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 800000);
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_gap(int n);
        int r;
        if ((n % 60) < 15)
            return 0;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom_range(8, 30);
        if (r < 12)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [1:0] pick_command(bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return CMD_UNUSED;
        if (r < (filling ? 74 : 36))
            return CMD_INSERT;
        if (r < 88)
            return CMD_DELETE;
        return CMD_LIST;
    endfunction

    function automatic logic [7:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 8'($urandom_range(0, 18));
        if (r < 85)
            return 8'($urandom_range(0, 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(logic [1:0] cmd, logic signed [31:0] val, logic [7:0] pos);
        int   gap;
        req_t item;
        item.command  = cmd;
        item.value    = val;
        item.position = pos;
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
        gap = pick_gap(items_sent);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side: runs of stall or no stall, plus one long hold-off on request
    initial
    begin
        bit stall_now;
        int run;
        bit squeezed;
        squeezed = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (squeeze_req && !squeezed)
            begin
                squeezed = 1'b1;
                stall_now = 1'b1;
                run = SQUEEZE_CYCLES;
            end
            else
            begin
                stall_now = ($urandom_range(0, 2) == 0);
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            end
            repeat (run)
            begin
                rsp_stall <= stall_now;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(CMD_LIST, 32'sd0, 8'd0);
        send(CMD_DELETE, 32'sh7fffffff, 8'd0);
        send(CMD_UNUSED, 32'sh80000000, 8'd255);
        send(CMD_INSERT, 32'sh7fffffff, 8'd0);
        send(CMD_INSERT, 32'sh80000000, 8'd1);
        send(CMD_INSERT, 32'sd0, 8'd255);
        send(CMD_INSERT, -32'sd1, 8'd2);
        send(CMD_DELETE, 32'sd0, 8'd0);
        send(CMD_DELETE, 32'sd0, 8'd5);
        send(CMD_LIST, 32'sd0, 8'd0);
        for (int k = 0; k < 12; k++)
            send(CMD_INSERT, 32'shA5A50000 | k, 8'(k * 3));
        send(CMD_INSERT, 32'sh12345678, 8'd3);
        send(CMD_LIST, 32'sd0, 8'd0);
        send(CMD_DELETE, 32'sd0, 8'd16);
        send(CMD_DELETE, 32'sd0, 8'd1);
        send(CMD_DELETE, 32'sd0, 8'd255);

        // alternate fill-leaning and drain-leaning stretches to swing between empty and full
        for (int n = 0; n < 310; n++)
        begin
            if (n == 90)
                squeeze_req <= 1'b1;
            send(pick_command(((n / 40) % 2) == 0), pick_value(), pick_position());
        end
        req_valid <= 1'b0;

        repeat (2) @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0 && results_outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
